>>> rtl/core/sprite_pixel_collision_macros.svh
// Assertion macros used by the checker file spc_checker.sv.
`ifndef SPRITE_PIXEL_COLLISION_MACROS_SVH
`define SPRITE_PIXEL_COLLISION_MACROS_SVH
// Implication checked at every clock edge, held off during reset.
`define SPC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the following cycle.
`define SPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> rtl/core/spc_pkg.sv
// ---------------------------------------------------------------------------
// spc_pkg
// Types, register indexes and constants of the sprite collision block.
// ---------------------------------------------------------------------------
`default_nettype none
package spc_pkg;
   localparam int MaskWDefault = 64;
   localparam int MaskHDefault = 64;
   localparam int CoordW = 12;
   localparam int TrigW  = 16;

   typedef enum logic [1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_QUERY   = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_A_WIDTH    = 3'd0,
      REG_A_HEIGHT   = 3'd1,
      REG_B_WIDTH    = 3'd2,
      REG_B_HEIGHT   = 3'd3,
      REG_THRESHOLD  = 3'd4,
      REG_A_ROTATES  = 3'd5,
      REG_A_PIX_MODE = 3'd6,
      REG_B_PIX_MODE = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROT1,
      ST_ROT2,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   // Configuration as seen by the scan engine.
   typedef struct packed {
      logic [6:0] a_width;
      logic [6:0] a_height;
      logic [6:0] b_width;
      logic [6:0] b_height;
      logic [7:0] alpha_threshold;
      logic       a_rotates;
      logic       a_pixel_mode;
      logic       b_pixel_mode;
   } cfg_type;
endpackage
`default_nettype wire

>>> rtl/core/spc_scan.sv
// ---------------------------------------------------------------------------
// spc_scan
// Holds both opacity masks and walks the overlap rectangle of a pixel query.
// ---------------------------------------------------------------------------
`default_nettype none
module spc_scan
   import spc_pkg::*;
#(
   parameter int MASK_W = MaskWDefault,
   parameter int MASK_H = MaskHDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     wr_en,
   input  logic                     wr_sel_b,
   input  logic [5:0]               wr_x,
   input  logic [5:0]               wr_y,
   input  logic                     wr_bit,
   input  logic                     start,
   input  logic signed [CoordW-1:0] a_left,
   input  logic signed [CoordW-1:0] a_top,
   input  logic signed [CoordW-1:0] b_left,
   input  logic signed [CoordW-1:0] b_top,
   input  logic signed [TrigW-1:0]  cos_value,
   input  logic signed [TrigW-1:0]  sin_value,
   output logic                     busy,
   output logic                     done,
   output logic                     hit
);
   localparam int Depth = MASK_W * MASK_H;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

   logic mem_a [Depth];
   logic mem_b [Depth];

   state_type state_ff, state_in;
   logic signed [13:0] ox_ff, oy_ff, ow_ff, oh_ff;
   logic signed [13:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [TrigW-1:0] cs_ff, sn_ff;
   logic [6:0] x_ff, y_ff;
   logic signed [31:0] pxc_ff, pys_ff, pxs_ff, pyc_ff;
   logic ok_ff, rd_a_ff, rd_b_ff, hit_ff;

   // Overlap rectangle from the query corners.
   logic signed [13:0] sax, say, sbx, sby, aex, aey, bex, bey, omx, omy, oex, oey;
   always_comb begin
      sax = 14'(a_left);  say = 14'(a_top);
      sbx = 14'(b_left);  sby = 14'(b_top);
      aex = sax + 14'(cfg.a_width);   aey = say + 14'(cfg.a_height);
      bex = sbx + 14'(cfg.b_width);   bey = sby + 14'(cfg.b_height);
      omx = (sax > sbx) ? sax : sbx;  omy = (say > sby) ? say : sby;
      oex = (aex < bex) ? aex : bex;  oey = (aey < bey) ? aey : bey;
   end

   // Sprite-local coordinates of the current pixel.
   logic signed [13:0] lx1, ly1, lx2, ly2, dx2, dy2;
   always_comb begin
      lx1 = ox_ff - ax_ff + 14'(x_ff);
      ly1 = oy_ff - ay_ff + 14'(y_ff);
      lx2 = ox_ff - bx_ff + 14'(x_ff);
      ly2 = oy_ff - by_ff + 14'(y_ff);
      dx2 = (lx1 <<< 1) - 14'(cfg.a_width);
      dy2 = (ly1 <<< 1) - 14'(cfg.a_height);
   end

   // Rotated sums; division by 2^15 truncates toward zero.
   logic signed [34:0] sx, sy, qx, qy;
   always_comb begin
      sx = (35'(cfg.a_width) <<< 14) + 35'(pxc_ff) - 35'(pys_ff);
      sy = (35'(cfg.a_height) <<< 14) + 35'(pxs_ff) + 35'(pyc_ff);
      qx = (sx + (sx[34] ? 35'sd32767 : 35'sd0)) >>> 15;
      qy = (sy + (sy[34] ? 35'sd32767 : 35'sd0)) >>> 15;
   end

   logic signed [13:0] ux, uy;
   logic in_a, in_b, in_mask;
   logic [AddrW-1:0] addr_a, addr_b;
   always_comb begin
      ux = cfg.a_rotates ? 14'(qx) : lx1;
      uy = cfg.a_rotates ? 14'(qy) : ly1;
      in_a = (ux >= 0) && (ux < 14'(cfg.a_width)) && (uy >= 0)
             && (uy < 14'(cfg.a_height));
      in_b = (lx2 >= 0) && (lx2 < 14'(cfg.b_width)) && (ly2 >= 0)
             && (ly2 < 14'(cfg.b_height));
      in_mask = (ux < 14'(MASK_W)) && (uy < 14'(MASK_H))
                && (lx2 < 14'(MASK_W)) && (ly2 < 14'(MASK_H));
      addr_a = AddrW'(32'(uy) * MASK_W + 32'(ux));
      addr_b = AddrW'(32'(ly2) * MASK_W + 32'(lx2));
   end

   logic last_x, last_y;
   assign last_x = (14'(x_ff) + 14'sd1) >= ow_ff;
   assign last_y = (14'(y_ff) + 14'sd1) >= oh_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) begin
            state_in = ((oex - omx) > 0 && (oey - omy) > 0) ? ST_ROT1 : ST_DONE;
         end
         ST_ROT1:  state_in = cfg.a_rotates ? ST_ROT2 : ST_READ;
         ST_ROT2:  state_in = ST_READ;
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (ok_ff && rd_a_ff && rd_b_ff) state_in = ST_DONE;
            else if (last_x && last_y) state_in = ST_DONE;
            else state_in = ST_ROT1;
         end
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != ST_IDLE);
      done = (state_ff == ST_DONE);
      hit  = hit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (state_ff == ST_IDLE && start) begin
         ox_ff <= omx; oy_ff <= omy;
         ow_ff <= oex - omx; oh_ff <= oey - omy;
         ax_ff <= sax; ay_ff <= say; bx_ff <= sbx; by_ff <= sby;
         cs_ff <= cos_value; sn_ff <= sin_value;
         x_ff <= '0; y_ff <= '0; hit_ff <= 1'b0;
      end
      if (state_ff == ST_ROT1) begin
         pxc_ff <= 32'(dx2) * 32'(cs_ff);
         pys_ff <= 32'(dy2) * 32'(sn_ff);
         pxs_ff <= 32'(dx2) * 32'(sn_ff);
         pyc_ff <= 32'(dy2) * 32'(cs_ff);
      end
      if (state_ff == ST_READ) begin
         ok_ff <= in_a && in_b && in_mask;
      end
      if (state_ff == ST_CHECK) begin
         if (ok_ff && rd_a_ff && rd_b_ff) begin
            hit_ff <= 1'b1;
         end else if (last_x) begin
            x_ff <= '0;
            y_ff <= y_ff + 7'd1;
         end else begin
            x_ff <= x_ff + 7'd1;
         end
      end
   end

   // Synchronous mask memories with a registered read.
   always_ff @(posedge clock) begin
      if (wr_en && !wr_sel_b) begin
         mem_a[AddrW'(32'(wr_y) * MASK_W + 32'(wr_x))] <= wr_bit;
      end
      rd_a_ff <= mem_a[addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_sel_b) begin
         mem_b[AddrW'(32'(wr_y) * MASK_W + 32'(wr_x))] <= wr_bit;
      end
      rd_b_ff <= mem_b[addr_b];
   end
endmodule
`default_nettype wire

>>> rtl/core/sprite_pixel_collision.sv
// ---------------------------------------------------------------------------
// sprite_pixel_collision
// Rectangle or pixel-exact collision test between two sprites.
// ---------------------------------------------------------------------------
// Mask writes give no word. A rectangle query, or one with an inactive or
// non-collidable sprite, is answered through rect_ff and then rsp_valid_ff.
// A pixel query walks the overlap rectangle one pixel per mask read, through
// ROT1, ROT2 (only with rotation, for the multiply stage), READ and CHECK for
// each pixel; it stops at the first opaque pair. The block takes one item
// at a time and holds the answer in an output register.
`default_nettype none
module sprite_pixel_collision
   import spc_pkg::*;
#(
   parameter int MASK_W = MaskWDefault,
   parameter int MASK_H = MaskHDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [7:0]               csr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_opcode,
   input  logic [5:0]               req_pixel_x,
   input  logic [5:0]               req_pixel_y,
   input  logic [7:0]               req_alpha,
   input  logic signed [CoordW-1:0] req_a_left,
   input  logic signed [CoordW-1:0] req_a_top,
   input  logic signed [CoordW-1:0] req_b_left,
   input  logic signed [CoordW-1:0] req_b_top,
   input  logic [2:0]               req_status_flags,
   input  logic signed [TrigW-1:0]  req_cos_value,
   input  logic signed [TrigW-1:0]  req_sin_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_collided
);
   cfg_type cfg_ff;
   logic rsp_valid_ff, rsp_collided_ff, rect_ff, rect_hit_ff;
   logic busy, done, hit, acc, query, pix, wr, in_range;
   logic signed [13:0] ax, ay, bx, by;
   logic signed [13:0] aw, ah, bw, bh;

   assign csr_ready = 1'b1;
   assign req_ready = !busy && !rect_ff && !rsp_valid_ff;
   assign acc = req_valid && req_ready;
   assign query = acc && (opcode_type'(req_opcode) == OP_QUERY);
   assign pix = req_status_flags == 3'b111 && cfg_ff.a_pixel_mode && cfg_ff.b_pixel_mode;
   assign in_range = (32'(req_pixel_x) < MASK_W) && (32'(req_pixel_y) < MASK_H);
   assign wr = acc && (opcode_type'(req_opcode) == OP_WRITE_A
                       || opcode_type'(req_opcode) == OP_WRITE_B) && in_range;

   // Sizes are widened into signed values so the edge compares stay signed.
   always_comb begin
      ax = 14'(req_a_left); ay = 14'(req_a_top);
      bx = 14'(req_b_left); by = 14'(req_b_top);
      aw = 14'(cfg_ff.a_width);  ah = 14'(cfg_ff.a_height);
      bw = 14'(cfg_ff.b_width);  bh = 14'(cfg_ff.b_height);
   end

   spc_scan #(.MASK_W(MASK_W), .MASK_H(MASK_H)) u_scan (
      .clock, .reset, .cfg(cfg_ff),
      .wr_en(wr), .wr_sel_b(req_opcode[0]), .wr_x(req_pixel_x), .wr_y(req_pixel_y),
      .wr_bit(req_alpha > cfg_ff.alpha_threshold),
      .start(query && pix),
      .a_left(req_a_left), .a_top(req_a_top), .b_left(req_b_left), .b_top(req_b_top),
      .cos_value(req_cos_value), .sin_value(req_sin_value),
      .busy, .done, .hit
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_collided = rsp_collided_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{7'd64, 7'd64, 7'd64, 7'd64, 8'd127, 1'b0, 1'b0, 1'b0};
         rsp_valid_ff <= 1'b0;
         rect_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (reg_index_type'(csr_index))
               REG_A_WIDTH:    cfg_ff.a_width <= csr_data[6:0];
               REG_A_HEIGHT:   cfg_ff.a_height <= csr_data[6:0];
               REG_B_WIDTH:    cfg_ff.b_width <= csr_data[6:0];
               REG_B_HEIGHT:   cfg_ff.b_height <= csr_data[6:0];
               REG_THRESHOLD:  cfg_ff.alpha_threshold <= csr_data;
               REG_A_ROTATES:  cfg_ff.a_rotates <= csr_data[0];
               REG_A_PIX_MODE: cfg_ff.a_pixel_mode <= csr_data[0];
               REG_B_PIX_MODE: cfg_ff.b_pixel_mode <= csr_data[0];
               default: ;
            endcase
         end
         rect_ff <= query && !pix;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end else if (rect_ff || done) begin
            rsp_valid_ff <= 1'b1;
         end
      end
      if (query && !pix) begin
         rect_hit_ff <= (req_status_flags == 3'b111)
            && (ax < bx + bw) && (ax + aw > bx)
            && (ay < by + bh) && (ay + ah > by);
      end
      if (rect_ff) rsp_collided_ff <= rect_hit_ff;
      else if (done) rsp_collided_ff <= hit;
   end
endmodule
`default_nettype wire

>>> rtl/core/spc_checker.sv
// ---------------------------------------------------------------------------
// spc_checker
// Port-level checks on the sprite collision block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sprite_pixel_collision_macros.svh"
module spc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_collided
);
   // One item at a time: no new item while a result word waits.
   `SPC_ASSERT_IMP(no_accept_while_rsp, clock, reset, rsp_valid, !req_ready)
   // A waiting result word holds its value.
   `SPC_ASSERT_NEXT(rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_collided))
   // After delivery the output is empty in the following cycle.
   `SPC_ASSERT_NEXT(rsp_drops, clock, reset, rsp_valid && rsp_ready, !rsp_valid)
   // A result word on the bus always carries a known answer.
   `SPC_ASSERT_IMP(rsp_known, clock, reset, rsp_valid, !$isunknown(rsp_collided))
endmodule

bind sprite_pixel_collision spc_checker u_spc_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_collided
);
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sprite collision testbench
// Runs rectangle queries, loads both opacity masks, then runs rectangle and
// pixel-exact queries under several register settings and flow-control
// patterns. Each query's answer is predicted from a local copy of the masks and registers and compared in order.
// ---------------------------------------------------------------------------
module tb;
   import spc_pkg::*;

   typedef struct {
      opcode_type        op;
      logic [5:0]        px;
      logic [5:0]        py;
      logic [7:0]        alpha;
      logic signed [11:0] al;
      logic signed [11:0] at;
      logic signed [11:0] bl;
      logic signed [11:0] bt;
      logic [2:0]        flags;
      logic signed [15:0] cs;
      logic signed [15:0] sn;
   } sprite_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [7:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_opcode = '0;
   logic [5:0] req_pixel_x = '0;
   logic [5:0] req_pixel_y = '0;
   logic [7:0] req_alpha = '0;
   logic signed [11:0] req_a_left = '0;
   logic signed [11:0] req_a_top = '0;
   logic signed [11:0] req_b_left = '0;
   logic signed [11:0] req_b_top = '0;
   logic [2:0] req_status_flags = '0;
   logic signed [15:0] req_cos_value = '0;
   logic signed [15:0] req_sin_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_collided;

   sprite_item_type pending[$];
   bit expected_hits[$];
   bit opaque_a[4096];
   bit opaque_b[4096];
   int width_a = 64, height_a = 64, width_b = 64, height_b = 64;
   int threshold = 127;
   bit rotate_a = 0, pixel_a = 0, pixel_b = 0;
   int send_idle_pct = 0, stall_pct = 0;
   int errors = 0;
   bit req_taken = 0;

   sprite_pixel_collision dut (.*);

   always #4 clock = ~clock;

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic bit pixel_hit(longint ax, longint ay, longint bx, longint by,
                                    longint cs, longint sn);
      longint aw, ah, bw, bh, ox, oy, ow, oh, x1, y1, x2, y2, dx, dy;
      aw = width_a; ah = height_a; bw = width_b; bh = height_b;
      ox = ax > bx ? ax : bx;
      oy = ay > by ? ay : by;
      ow = ((ax + aw < bx + bw) ? ax + aw : bx + bw) - ox;
      oh = ((ay + ah < by + bh) ? ay + ah : by + bh) - oy;
      if (ow <= 0 || oh <= 0) return 0;
      for (longint y = 0; y < oh; y++) begin
         for (longint x = 0; x < ow; x++) begin
            x1 = ox - ax + x; y1 = oy - ay + y;
            x2 = ox - bx + x; y2 = oy - by + y;
            if (rotate_a) begin
               dx = 2 * x1 - aw;
               dy = 2 * y1 - ah;
               // Signed division truncates toward zero, as the hardware does.
               x1 = (aw * 16384 + dx * cs - dy * sn) / 32768;
               y1 = (ah * 16384 + dx * sn + dy * cs) / 32768;
            end
            if (x1 >= 0 && x1 < aw && y1 >= 0 && y1 < ah && x1 < 64 && y1 < 64 &&
                x2 >= 0 && x2 < bw && y2 >= 0 && y2 < bh && x2 < 64 && y2 < 64 &&
                opaque_a[y1 * 64 + x1] && opaque_b[y2 * 64 + x2])
               return 1;
         end
      end
      return 0;
   endfunction

   function automatic bit collision_for(sprite_item_type it);
      longint ax, ay, bx, by;
      ax = it.al; ay = it.at; bx = it.bl; by = it.bt;
      if (it.flags != 3'b111) return 0;
      if (pixel_a && pixel_b) return pixel_hit(ax, ay, bx, by, it.cs, it.sn);
      return ax < bx + width_b && ax + width_a > bx &&
             ay < by + height_b && ay + height_a > by;
   endfunction

   // Driver: a word stays on the bus until it is taken.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               sprite_item_type it;
               it = pending.pop_front();
               req_opcode <= it.op;
               req_pixel_x <= it.px;
               req_pixel_y <= it.py;
               req_alpha <= it.alpha;
               req_a_left <= it.al;
               req_a_top <= it.at;
               req_b_left <= it.bl;
               req_b_top <= it.bt;
               req_status_flags <= it.flags;
               req_cos_value <= it.cs;
               req_sin_value <= it.sn;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= $urandom_range(99) >= stall_pct;
      end
   end

   // Monitor: update the mask copy or predict on each accepted word, and check each delivered result word.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            sprite_item_type it;
            it.op = opcode_type'(req_opcode);
            it.px = req_pixel_x; it.py = req_pixel_y; it.alpha = req_alpha;
            it.al = req_a_left; it.at = req_a_top; it.bl = req_b_left; it.bt = req_b_top;
            it.flags = req_status_flags; it.cs = req_cos_value; it.sn = req_sin_value;
            case (it.op)
               OP_WRITE_A: opaque_a[it.py * 64 + it.px] = it.alpha > threshold;
               OP_WRITE_B: opaque_b[it.py * 64 + it.px] = it.alpha > threshold;
               OP_QUERY: expected_hits.push_back(collision_for(it));
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_hits.size() == 0) begin
               report_mismatch("result word with nothing expected");
            end else begin
               bit hit;
               hit = expected_hits.pop_front();
               if (rsp_collided !== hit)
                  report_mismatch($sformatf("collided %b, expected %b", rsp_collided, hit));
            end
         end
      end
   end

   task automatic csr_write(input reg_index_type idx, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[7:0];
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         REG_A_WIDTH: width_a = value;
         REG_A_HEIGHT: height_a = value;
         REG_B_WIDTH: width_b = value;
         REG_B_HEIGHT: height_b = value;
         REG_THRESHOLD: threshold = value;
         REG_A_ROTATES: rotate_a = value[0];
         REG_A_PIX_MODE: pixel_a = value[0];
         default: pixel_b = value[0];
      endcase
   endtask

   task automatic configure(input int aw, ah, bw, bh, thr, rot, pa, pb);
      csr_write(REG_A_WIDTH, aw);
      csr_write(REG_A_HEIGHT, ah);
      csr_write(REG_B_WIDTH, bw);
      csr_write(REG_B_HEIGHT, bh);
      csr_write(REG_THRESHOLD, thr);
      csr_write(REG_A_ROTATES, rot);
      csr_write(REG_A_PIX_MODE, pa);
      csr_write(REG_B_PIX_MODE, pb);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      do begin
         @(posedge clock);
         #1;
      end while (pending.size() != 0 || req_valid || expected_hits.size() != 0);
      // Mask writes give no word; let the last one settle.
      repeat (40) @(posedge clock);
   endtask

   function automatic sprite_item_type mask_write(opcode_type op, int x, int y, int a);
      sprite_item_type it;
      it.op = op;
      it.px = 6'(x); it.py = 6'(y); it.alpha = 8'(a);
      it.al = 12'($urandom); it.at = '0; it.bl = '0; it.bt = 12'($urandom);
      it.flags = '0; it.cs = 16'($urandom); it.sn = '0;
      return it;
   endfunction

   function automatic sprite_item_type query(int al, at, bl, bt, flags, cs, sn);
      sprite_item_type it;
      it.op = OP_QUERY;
      it.al = 12'(al); it.at = 12'(at); it.bl = 12'(bl); it.bt = 12'(bt);
      it.flags = 3'(flags); it.cs = 16'(cs); it.sn = 16'(sn);
      it.px = 6'($urandom); it.py = '0; it.alpha = 8'($urandom);
      return it;
   endfunction

   function automatic int trig_value();
      int pick;
      pick = $urandom_range(7);
      if (pick == 0) return 16384;
      if (pick == 1) return -16384;
      if (pick == 2) return 0;
      return int'($urandom_range(32768)) - 16384;
   endfunction

   function automatic sprite_item_type random_item();
      int r, al, at, span;
      r = $urandom_range(99);
      if (r < 25)
         return mask_write(r < 12 ? OP_WRITE_A : OP_WRITE_B, $urandom_range(15),
                           $urandom_range(15), $urandom_range(255));
      if (r < 28) begin
         sprite_item_type it;
         it = query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         it.op = OP_NONE;
         return it;
      end
      if (r < 38)
         return query($urandom, $urandom, $urandom, $urandom, $urandom_range(7),
                      trig_value(), trig_value());
      al = int'($urandom_range(4095)) - 2048;
      at = int'($urandom_range(4095)) - 2048;
      span = width_a > width_b ? width_a : width_b;
      return query(al, at, al + int'($urandom_range(2 * span + 2)) - span - 1,
                   at + int'($urandom_range(2 * span + 2)) - span - 1,
                   $urandom_range(3) != 0 ? 7 : $urandom_range(7), trig_value(), trig_value());
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Rectangle mode at reset sizes: every status combination and the
      // coordinate extremes, plus an unused opcode.
      for (int f = 0; f < 8; f++) pending.push_back(query(10, 10, 40, 40, f, 0, 0));
      pending.push_back(query(-2048, -2048, 2047, 2047, 7, 0, 0));
      pending.push_back(query(2047, 2047, -2048, -2048, 7, 0, 0));
      pending.push_back(query(-2048, -2048, -1985, -1985, 7, 0, 0));
      pending.push_back(query(-2048, -2048, -1984, -2048, 7, 0, 0));
      pending.push_back(query(100, 100, 163, 36, 7, 16384, -16384));
      begin
         sprite_item_type it;
         it = query(0, 0, 0, 0, 7, 0, 0);
         it.op = OP_NONE;
         pending.push_back(it);
      end
      drain();

      // Load the corner of both masks that pixel-mode sprites cover. Pixel
      // tests below keep every sprite within six by six pixels, so a scan
      // never reads an unwritten bit.
      for (int y = 0; y < 6; y++)
         for (int x = 0; x < 6; x++) begin
            pending.push_back(mask_write(OP_WRITE_A, x, y, $urandom_range(255)));
            pending.push_back(mask_write(OP_WRITE_B, x, y, $urandom_range(255)));
         end
      pending.push_back(mask_write(OP_WRITE_A, 0, 0, 255));
      drain();

      // Pixel mode at the largest tested size, then rotation by quarter turns.
      configure(6, 6, 6, 6, 127, 0, 1, 1);
      pending.push_back(query(5, 5, 5, 5, 7, 0, 0));
      pending.push_back(query(0, 0, 5, 5, 7, 0, 0));
      drain();
      configure(6, 6, 6, 6, 127, 1, 1, 1);
      pending.push_back(query(0, 0, 0, 0, 7, 16384, 0));
      pending.push_back(query(0, 0, 0, 0, 7, -16384, 0));
      pending.push_back(query(0, 0, 0, 0, 7, 0, 16384));
      pending.push_back(query(0, 0, 0, 0, 7, 0, -16384));
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         int aw, ah, bw, bh;
         aw = $urandom_range(1, 6); ah = $urandom_range(1, 6);
         bw = $urandom_range(1, 6); bh = $urandom_range(1, 6);
         if (phase == 1) begin
            aw = 1; ah = 1; bw = 1; bh = 1;
         end else if (phase == 6) begin
            aw = 6; ah = 6; bw = 6; bh = 6;
         end
         configure(aw, ah, bw, bh, phase == 2 ? 0 : phase == 5 ? 255 : $urandom_range(255),
                   $urandom_range(1), phase % 3 != 2, phase != 4);
         case (phase % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 60; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 60; end
            default: begin send_idle_pct = 8; stall_pct = 8; end
         endcase
         for (int i = 0; i < 6; i++) pending.push_back(random_item());
         drain();
      end

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
